// ----- rtl/tsbc_pkg.sv -----
// shared types and constants for the texture slot binding cache
package tsbc_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int ID_W      = 32;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int PT_W      = IDX_W + 1;

    typedef logic [IDX_W-1:0]       slot_t;
    typedef logic signed [PT_W-1:0] ptr_t;
    typedef logic [ID_W-1:0]        tex_id_t;

    typedef enum logic [1:0] {
        CMD_USE       = 2'd0,
        CMD_PUSH      = 2'd1,
        CMD_EMPTY_BUF = 2'd2,
        CMD_EMPTY_ALL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    localparam ptr_t PTR_NONE = ptr_t'(-1);
    localparam ptr_t PTR_LAST = ptr_t'(NUM_SLOTS - 1);

    // slot index widened to the signed pointer form
    function automatic ptr_t to_ptr(input slot_t s);
        to_ptr = ptr_t'({1'b0, s});
    endfunction

endpackage

// ----- rtl/tsbc_ifs.sv -----
// request and response channel interfaces for the binding cache
interface tsbc_req_if;
    logic              valid;
    logic              ready;
    tsbc_pkg::cmd_t    cmd;
    tsbc_pkg::tex_id_t tex_id;

    modport source (output valid, output cmd, output tex_id, input ready);
    modport sink   (input valid, input cmd, input tex_id, output ready);
endinterface

interface tsbc_rsp_if;
    logic            valid;
    logic            ready;
    tsbc_pkg::slot_t slot;
    logic            hit;
    logic            bind_issued;
    logic            activate_issued;
    logic            overflow;
    tsbc_pkg::ptr_t  buffer_top;

    modport source (output valid, output slot, output hit, output bind_issued,
                    output activate_issued, output overflow, output buffer_top,
                    input ready);
    modport sink   (input valid, input slot, input hit, input bind_issued,
                    input activate_issued, input overflow, input buffer_top,
                    output ready);
endinterface

// ----- rtl/tsbc_ram.sv -----
// generic single-port-write, registered-read ram
module tsbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/texture_slot_binding_cache.sv -----
// texture slot binding cache top level: slot table scan, bind and clear control
//
// usage
// - req channel carries one command beat: cmd (use, push, empty pinned, empty all)
//   and a 32-bit tex_id; rsp channel returns exactly one result beat per command
// - slot ids live in a 16-entry ram with registered read; a per-slot nonzero flag
//   in flops marks entries that hold a texture, so reset needs no clearing pass
// - a use scans slots 0..15 one read per cycle and stops at the first match;
//   a push reads only the next pinned slot; empty commands walk the cleared range
//   in ascending order to follow the active-slot changes
// - from command beat to result beat: the command is latched, one ram read is
//   issued per scanned slot and checked once the registered read returns, then
//   write back loads the result register
// - one command at a time, taken only after the previous one writes back; an
//   empty-all scans every slot, a use up to its first match, a push only one
// - an overflowing push and an empty-pinned with no pinned slots skip the scan
// - rst_n clears the nonzero flags, pinned top and active slot to -1, and the
//   result valid flag; ram contents are ignored until written
// - when rsp stalls, the finished result waits in the result register; a new
//   command is still taken and processed up to write back, then holds there
module texture_slot_binding_cache (
    input  logic clk,
    input  logic rst_n,
    tsbc_req_if.sink   req,
    tsbc_rsp_if.source rsp
);
    import tsbc_pkg::*;

    // control state
    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    tex_id_t                id_reg, id_next;
    slot_t                  last_reg, last_next;
    slot_t                  scan_idx_reg, scan_idx_next;
    logic                   issue_reg, issue_next;
    logic                   chk_valid_reg, chk_valid_next;
    slot_t                  chk_idx_reg, chk_idx_next;
    logic                   found_reg, found_next;
    slot_t                  found_idx_reg, found_idx_next;
    logic                   cand_valid_reg, cand_valid_next;
    slot_t                  cand_reg, cand_next;
    logic                   chg_reg, chg_next;
    logic                   ovf_reg, ovf_next;

    // architectural state
    ptr_t                   pinned_reg, pinned_next;
    ptr_t                   active_reg, active_next;
    logic [NUM_SLOTS-1:0]   nz_reg, nz_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    slot_t                  slot_reg, slot_next;
    logic                   hit_reg, hit_next;
    logic                   bind_reg, bind_next;
    logic                   act_reg, act_next;
    logic                   ovf_out_reg, ovf_out_next;
    ptr_t                   top_reg, top_next;

    // ram port
    logic                   ram_we;
    slot_t                  ram_waddr;
    tex_id_t                ram_wdata;
    tex_id_t                ram_rdata;

    logic                   req_fire;
    logic                   out_free;
    tex_id_t                eff_data;
    logic                   eq;
    logic                   scan_end;
    slot_t                  use_slot;

    tsbc_ram #(
        .WIDTH (ID_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // an entry never written or cleared reads as empty
    assign eff_data = nz_reg[chk_idx_reg] ? ram_rdata : '0;
    assign eq       = (eff_data == id_reg);
    assign scan_end = chk_valid_reg &&
                      ((chk_idx_reg == last_reg) || ((cmd_reg == CMD_USE) && eq));
    assign use_slot = found_reg ? found_idx_reg : (cand_valid_reg ? cand_reg : '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if ((req.cmd == CMD_PUSH && pinned_reg == PTR_LAST) ||
                        (req.cmd == CMD_EMPTY_BUF && pinned_reg == PTR_NONE))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        last_next       = last_reg;
        scan_idx_next   = scan_idx_reg;
        issue_next      = issue_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        cand_valid_next = cand_valid_reg;
        cand_next       = cand_reg;
        chg_next        = chg_reg;
        ovf_next        = ovf_reg;
        pinned_next     = pinned_reg;
        active_next     = active_reg;
        nz_next         = nz_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        slot_next       = slot_reg;
        hit_next        = hit_reg;
        bind_next       = bind_reg;
        act_next        = act_reg;
        ovf_out_next    = ovf_out_reg;
        top_next        = top_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = id_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next        = req.cmd;
                    id_next         = req.tex_id;
                    issue_next      = 1'b1;
                    found_next      = 1'b0;
                    cand_valid_next = 1'b0;
                    chg_next        = 1'b0;
                    ovf_next        = 1'b0;
                    scan_idx_next   = '0;
                    last_next       = slot_t'(NUM_SLOTS - 1);
                    unique case (req.cmd)
                        CMD_PUSH:
                        begin
                            ovf_next      = (pinned_reg == PTR_LAST);
                            scan_idx_next = slot_t'(pinned_reg + ptr_t'(1));
                            last_next     = slot_t'(pinned_reg + ptr_t'(1));
                        end
                        CMD_EMPTY_BUF:
                        begin
                            last_next = slot_t'(pinned_reg);
                        end
                        default:
                        begin
                            last_next = slot_t'(NUM_SLOTS - 1);
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // one ram read issued per cycle, checked in the next cycle
                chk_valid_next = issue_reg;
                chk_idx_next   = scan_idx_reg;
                if (issue_reg)
                begin
                    issue_next    = (scan_idx_reg != last_reg);
                    scan_idx_next = scan_idx_reg + slot_t'(1);
                end
                if (chk_valid_reg)
                begin
                    unique case (cmd_reg)
                        CMD_USE:
                        begin
                            if (eq)
                            begin
                                found_next     = 1'b1;
                                found_idx_next = chk_idx_reg;
                            end
                            else if (eff_data == '0 && to_ptr(chk_idx_reg) > pinned_reg)
                            begin
                                cand_valid_next = 1'b1;
                                cand_next       = chk_idx_reg;
                            end
                        end
                        CMD_PUSH:
                        begin
                            found_next = eq;
                        end
                        CMD_EMPTY_BUF, CMD_EMPTY_ALL:
                        begin
                            // each nonzero slot is activated then cleared
                            if (eff_data != '0)
                            begin
                                if (active_reg != to_ptr(chk_idx_reg))
                                begin
                                    chg_next = 1'b1;
                                end
                                active_next          = to_ptr(chk_idx_reg);
                                nz_next[chk_idx_reg] = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    bind_next      = 1'b0;
                    act_next       = 1'b0;
                    ovf_out_next   = 1'b0;
                    slot_next      = '0;
                    unique case (cmd_reg)
                        CMD_USE:
                        begin
                            slot_next   = use_slot;
                            hit_next    = found_reg;
                            act_next    = (active_reg != to_ptr(use_slot));
                            active_next = to_ptr(use_slot);
                            if (!found_reg)
                            begin
                                bind_next         = 1'b1;
                                ram_we            = 1'b1;
                                ram_waddr         = use_slot;
                                nz_next[use_slot] = (id_reg != '0);
                            end
                        end
                        CMD_PUSH:
                        begin
                            if (ovf_reg)
                            begin
                                ovf_out_next = 1'b1;
                            end
                            else
                            begin
                                slot_next   = last_reg;
                                pinned_next = to_ptr(last_reg);
                                if (!found_reg)
                                begin
                                    bind_next         = 1'b1;
                                    act_next          = (active_reg != to_ptr(last_reg));
                                    active_next       = to_ptr(last_reg);
                                    ram_we            = 1'b1;
                                    ram_waddr         = last_reg;
                                    nz_next[last_reg] = (id_reg != '0);
                                end
                            end
                        end
                        CMD_EMPTY_BUF, CMD_EMPTY_ALL:
                        begin
                            act_next    = chg_reg;
                            pinned_next = PTR_NONE;
                        end
                        default:
                        begin
                        end
                    endcase
                    top_next = (cmd_reg == CMD_EMPTY_BUF || cmd_reg == CMD_EMPTY_ALL) ?
                               PTR_NONE : pinned_next;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_reg      <= 1'b0;
            chk_valid_reg  <= 1'b0;
            pinned_reg     <= PTR_NONE;
            active_reg     <= PTR_NONE;
            nz_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            chk_valid_reg  <= chk_valid_next;
            pinned_reg     <= pinned_next;
            active_reg     <= active_next;
            nz_reg         <= nz_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        last_reg       <= last_next;
        scan_idx_reg   <= scan_idx_next;
        chk_idx_reg    <= chk_idx_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        cand_valid_reg <= cand_valid_next;
        cand_reg       <= cand_next;
        chg_reg        <= chg_next;
        ovf_reg        <= ovf_next;
        slot_reg       <= slot_next;
        hit_reg        <= hit_next;
        bind_reg       <= bind_next;
        act_reg        <= act_next;
        ovf_out_reg    <= ovf_out_next;
        top_reg        <= top_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.slot            = slot_reg;
    assign rsp.hit             = hit_reg;
    assign rsp.bind_issued     = bind_reg;
    assign rsp.activate_issued = act_reg;
    assign rsp.overflow        = ovf_out_reg;
    assign rsp.buffer_top      = top_reg;

    // ram is only written at write back
    a_write_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_FIN))
        else $error("slot ram written outside write back");

    // a push checks a single slot and then writes back
    a_push_one_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && chk_valid_reg && cmd_reg == CMD_PUSH)
        |=> (state_reg == ST_FIN))
        else $error("push scan ran past its slot");

    // a hit never rebinds
    a_hit_no_bind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && bind_reg))
        else $error("hit and bind reported together");

    // overflow leaves the pinned region full and binds nothing
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ovf_out_reg) |-> (top_reg == PTR_LAST && !bind_reg && !act_reg))
        else $error("overflow with pinned region not full");

    // pinned top stays within -1 .. last slot
    a_pinned_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pinned_reg >= PTR_NONE) && (pinned_reg <= PTR_LAST))
        else $error("pinned top out of range");

endmodule

// ----- tb/tsbc_slot_checker.sv -----
// result predictor and checker for the texture slot binding cache channels
module tsbc_slot_checker (
    input  logic clk,
    input  logic rst_n,
    tsbc_req_if  req,
    tsbc_rsp_if  rsp,
    output int   pending,
    output int   mismatches
);
    import tsbc_pkg::*;

    typedef struct packed {
        slot_t slot;
        logic  hit;
        logic  bind_issued;
        logic  activate_issued;
        logic  overflow;
        ptr_t  buffer_top;
    } cache_result_t;

    // predicted table contents, pinned region and active slot
    tex_id_t       bound_id [NUM_SLOTS];
    int            pinned_top;
    int            active_slot;
    cache_result_t result_q [$];

    initial mismatches = 0;

    function automatic bit select_slot(input int s);
        bit changed;
        changed = (active_slot != s);
        active_slot = s;
        return changed;
    endfunction

    // clears nonzero slots 0..last in ascending order, each one made active first
    function automatic bit wipe_through(input int last);
        bit changed;
        changed = 1'b0;
        for (int i = 0; i <= last && i < NUM_SLOTS; i++)
        begin
            if (bound_id[i] != '0)
            begin
                if (select_slot(i))
                    changed = 1'b1;
                bound_id[i] = '0;
            end
        end
        return changed;
    endfunction

    function automatic cache_result_t resolve_command(input cmd_t c, input tex_id_t id);
        cache_result_t r;
        int            found;
        int            cand;
        int            s;
        bit            a;
        r = '0;
        case (c)
            CMD_USE:
            begin
                found = -1;
                cand  = -1;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (bound_id[i] == id)
                    begin
                        found = i;
                        break;
                    end
                    if (bound_id[i] == '0 && i > pinned_top)
                        cand = i;
                end
                if (found >= 0)
                begin
                    r.slot            = slot_t'(found);
                    r.hit             = 1'b1;
                    r.activate_issued = select_slot(found);
                end
                else
                begin
                    s = (cand >= 0) ? cand : 0;
                    r.slot            = slot_t'(s);
                    r.activate_issued = select_slot(s);
                    r.bind_issued     = 1'b1;
                    bound_id[s]       = id;
                end
            end
            CMD_PUSH:
            begin
                if (pinned_top + 1 >= NUM_SLOTS)
                    r.overflow = 1'b1;
                else
                begin
                    pinned_top++;
                    r.slot = slot_t'(pinned_top);
                    if (bound_id[pinned_top] != id)
                    begin
                        r.activate_issued    = select_slot(pinned_top);
                        r.bind_issued        = 1'b1;
                        bound_id[pinned_top] = id;
                    end
                end
            end
            CMD_EMPTY_BUF:
            begin
                r.activate_issued = wipe_through(pinned_top);
                pinned_top = -1;
            end
            default:
            begin
                a = wipe_through(pinned_top);
                pinned_top = -1;
                if (wipe_through(NUM_SLOTS - 1))
                    a = 1'b1;
                r.activate_issued = a;
            end
        endcase
        r.buffer_top = ptr_t'(pinned_top);
        return r;
    endfunction

    task automatic check_field(input string f, input logic signed [5:0] want,
                               input logic signed [5:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", f, want, got);
            mismatches++;
        end
    endtask

    // results are checked before commands are logged: a result never belongs
    // to a command taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        cache_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                bound_id[i] = '0;
            pinned_top  = -1;
            active_slot = -1;
            result_q.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("slot", 6'(want.slot), 6'(rsp.slot));
                    check_field("hit", 6'(want.hit), 6'(rsp.hit));
                    check_field("bind_issued", 6'(want.bind_issued),
                                6'(rsp.bind_issued));
                    check_field("activate_issued", 6'(want.activate_issued),
                                6'(rsp.activate_issued));
                    check_field("overflow", 6'(want.overflow), 6'(rsp.overflow));
                    check_field("buffer_top", 6'(want.buffer_top), 6'(rsp.buffer_top));
                end
            end
            if (req.valid && req.ready)
                result_q.push_back(resolve_command(req.cmd, req.tex_id));
            pending <= result_q.size();
        end
    end

endmodule

// ----- tb/tb_texture_slot_binding_cache.sv -----
// testbench top: clock, reset, command stimulus, result back-pressure and verdict
module tb_texture_slot_binding_cache;
    import tsbc_pkg::*;

    // ids reused from a pool bigger than the table so that uses both hit and evict
    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_BEATS = 800;

    logic    clk      = 1'b0;
    logic    rst_n    = 1'b0;
    bit      calm     = 1'b0;   // no idling on either side while set
    int      rsp_hold = 0;
    int      beats_sent = 0;
    int      pending;
    int      mismatches;
    tex_id_t id_pool [POOL_SIZE];

    tsbc_req_if req_ch ();
    tsbc_rsp_if rsp_ch ();

    texture_slot_binding_cache i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    tsbc_slot_checker i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always #4 clk = ~clk;

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly pooled ids, some zero, some fresh full-width values
    function automatic tex_id_t pool_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 90)
            return '0;
        return $urandom;
    endfunction

    // result side: ready drops for random stretches
    always @(posedge clk)
    begin
        if (rsp_hold > 0)
        begin
            rsp_hold     <= rsp_hold - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            rsp_hold     <= pick_gap();
        end
    end

    // one command beat; valid is left high on return so back-to-back beats
    // never lower and raise it within one step
    task automatic send_beat(input cmd_t c, input tex_id_t id);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.cmd    <= c;
        req_ch.tex_id <= id;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    // stop sending until every outstanding result has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        int kind;
        int run;
        req_ch.valid  = 1'b0;
        req_ch.cmd    = CMD_USE;
        req_ch.tex_id = '0;
        rsp_ch.ready  = 1'b0;
        foreach (id_pool[k])
            id_pool[k] = $urandom;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty slots hold zero, so a use of zero hits the lowest empty slot
        send_beat(CMD_USE, 32'h0000_0000);
        // misses fill from the top of the unpinned region downward
        send_beat(CMD_USE, 32'hFFFF_FFFF);
        send_beat(CMD_USE, 32'h0000_0001);
        // push of the id the slot already holds: no rebind, no activation
        send_beat(CMD_PUSH, 32'h0000_0000);
        send_beat(CMD_PUSH, 32'h1234_5678);
        send_beat(CMD_EMPTY_BUF, 32'h0000_0000);
        // empty pinned with nothing pinned
        send_beat(CMD_EMPTY_BUF, 32'hA5A5_A5A5);
        // fill the whole table as pinned, then overflow
        for (int k = 0; k < NUM_SLOTS; k++)
            send_beat(CMD_PUSH, 32'h5A5A_0000 + k);
        send_beat(CMD_PUSH, 32'hDEAD_BEEF);
        // miss with no free unpinned slot lands on slot 0 though it is pinned
        send_beat(CMD_USE, 32'h0F0F_F0F0);
        send_beat(CMD_EMPTY_ALL, 32'h0000_0000);
        drain();

        // random phase built from short runs of like commands
        while (beats_sent < RANDOM_BEATS)
        begin
            kind = $urandom_range(0, 99);
            calm <= ($urandom_range(0, 4) == 0);
            if (kind < 45)
            begin
                run = $urandom_range(4, 24);
                repeat (run) send_beat(CMD_USE, pool_id());
            end
            else if (kind < 70)
            begin
                // push runs long enough to overflow now and then, followed by uses
                run = $urandom_range(1, 18);
                repeat (run) send_beat(CMD_PUSH, pool_id());
                run = $urandom_range(0, 8);
                repeat (run) send_beat(CMD_USE, pool_id());
            end
            else if (kind < 78)
                send_beat(CMD_EMPTY_BUF, pool_id());
            else if (kind < 84)
                send_beat(CMD_EMPTY_ALL, $urandom);
            else if (kind < 96)
            begin
                // noise: any command, any id
                run = $urandom_range(1, 8);
                repeat (run) send_beat(cmd_t'($urandom_range(0, 3)), $urandom);
            end
            else
                drain();
        end

        drain();
        // catch any stray result after the last expected one
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- texture_slot_binding_cache.f -----
rtl/tsbc_pkg.sv
rtl/tsbc_ifs.sv
rtl/tsbc_ram.sv
rtl/texture_slot_binding_cache.sv
tb/tsbc_slot_checker.sv
tb/tb_texture_slot_binding_cache.sv
